[sv/sva_pkg.sv]
`timescale 1ns / 1ps

package sva_pkg;

	// default sizes
	localparam int VOICES_DEF = 16;
	localparam int PADS_DEF   = 32;
	localparam int TRACKS_DEF = 8;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int PAD_W   = 5;
	localparam int NOTE_W  = 7;
	localparam int VEL_W   = 7;
	localparam int TRK_W   = 8;
	localparam int TAG_W   = 32;
	localparam int SLOT_W  = 4;
	localparam int MASK_W  = 16;
	localparam int CNT_W   = 5;
	localparam int AGE_W   = 64;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_PAD_TRIGGER = 3'd0;
	localparam logic [OP_W-1:0] OP_NOTE_ON     = 3'd1;
	localparam logic [OP_W-1:0] OP_NOTE_OFF    = 3'd2;
	localparam logic [OP_W-1:0] OP_PAD_RELEASE = 3'd3;
	localparam logic [OP_W-1:0] OP_FINISHED    = 3'd4;
	localparam logic [OP_W-1:0] OP_PANIC       = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOADED_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_MASK  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		JOB_NONE,
		JOB_ALLOC,
		JOB_NOTE_OFF,
		JOB_RELEASE,
		JOB_FINISH,
		JOB_PANIC
	} job_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PAD_W-1:0]  pad;
		logic [NOTE_W-1:0] midi_note;
		logic [VEL_W-1:0]  velocity;
		logic [TRK_W-1:0]  track;
		logic [TAG_W-1:0]  trigger_tag;
		logic [SLOT_W-1:0] voice_slot;
	} item_t;

	typedef struct packed {
		logic              voice_started;
		logic [SLOT_W-1:0] started_slot;
		logic              stole_voice;
		logic [NOTE_W-1:0] start_note;
		logic [VEL_W-1:0]  start_velocity;
		logic              forwarded_to_synth;
		logic [PAD_W-1:0]  forwarded_pad;
		logic [MASK_W-1:0] stop_mask;
		logic [CNT_W-1:0]  active_count;
	} result_t;

endpackage

[sv/sva_stream_if.sv]
`timescale 1ns / 1ps

interface sva_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/sampler_voice_allocator.sv]
`timescale 1ns / 1ps
// note-off, pad release and allocating triggers scan all voices in ST_SCAN and ST_TAIL
//   before ST_UPDATE, which waits for a free output register; other items go from
//   ST_IDLE straight to ST_UPDATE. One item is in work at a time, as input is taken
//   only in ST_IDLE; scans share one voice-table read port and one compare unit
// reset: arst_n clears voice activity, active count, age counter and config registers

module sampler_voice_allocator #(
	parameter int VOICES = sva_pkg::VOICES_DEF,
	parameter int PADS   = sva_pkg::PADS_DEF,
	parameter int TRACKS = sva_pkg::TRACKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sva_stream_if.sink                    in_ch,
	sva_stream_if.source                  result,
	input  logic                          cfg_we,
	input  logic [sva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sva_pkg::CFG_W-1:0]     cfg_data
);
	import sva_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	// configuration registers
	logic        active_bank_q;
	logic [31:0] loaded_mask_q;
	logic [31:0] synth_mask_q;

	// control state
	state_t          state_q, state_d;
	job_t            job_q;
	logic [VW-1:0]   scan_idx_q;
	logic [VOICES-1:0] voice_active_q;
	logic [CW-1:0]   active_cnt_q;
	logic [AGE_W-1:0] age_counter_q;
	logic            out_valid_q;
	result_t         out_data_q;

	// captured item
	logic              fwd_q;
	logic [PAD_W-1:0]  fpad_q;
	logic [NOTE_W-1:0] key_note_q;
	logic [VEL_W-1:0]  vel_q;
	logic [TRK_W-1:0]  track_q;
	logic [TAG_W-1:0]  tag_q;
	logic [TAG_W-1:0]  store_tag_q;
	logic              is_trigger_q;
	logic [SLOT_W-1:0] slot_q;

	// voice table
	logic [AGE_W-1:0]  age_mem   [VOICES];
	logic [NOTE_W-1:0] note_mem  [VOICES];
	logic [TW-1:0]     track_mem [VOICES];
	logic [TAG_W-1:0]  trig_mem  [VOICES];

	// scan pipeline stage
	logic              valid_s1;
	logic [VW-1:0]     idx_s1;
	logic              active_s1;
	logic [AGE_W-1:0]  age_s1;
	logic [NOTE_W-1:0] note_s1;
	logic [TW-1:0]     track_s1;
	logic [TAG_W-1:0]  trig_s1;

	// scan results
	logic              free_found_q;
	logic [VW-1:0]     free_idx_q;
	logic [VW-1:0]     best_idx_q;
	logic [AGE_W-1:0]  best_age_q;
	logic [MASK_W-1:0] mask_q;

	// handshake and decode
	logic              in_xfer;
	logic              out_free;
	logic              do_update;
	logic [PAD_W-1:0]  pad_sel;
	logic              pad_ok;
	logic              rel_ok;
	job_t              job_d;
	logic              fwd_d;
	logic [PAD_W-1:0]  fpad_d;
	logic [NOTE_W-1:0] key_note_d;

	// update datapath
	logic [VW-1:0]     alloc_idx;
	logic [VW+SLOT_W-1:0] alloc_ext;
	logic [VW+SLOT_W-1:0] slot_ext;
	logic [VW-1:0]     slot_idx;
	logic              slot_ok;
	logic [CW-1:0]     cnt_next;
	logic [CW+CNT_W-1:0] cnt_ext;
	logic [TW-1:0]     store_track;
	result_t           res_d;

	// scan match helpers
	logic [VW+SLOT_W-1:0] idx_ext_s1;
	logic              in_mask_s1;
	logic              note_off_hit;
	logic              release_hit;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || result.ready;
	assign do_update = (state_q == ST_UPDATE) && out_free;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bank_q <= 1'b0;
			loaded_mask_q <= '0;
			synth_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_BANK: active_bank_q <= cfg_data[0];
				CFG_LOADED_MASK: loaded_mask_q <= cfg_data;
				CFG_SYNTH_MASK:  synth_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of the incoming item
	always_comb begin
		pad_sel = (in_ch.data.operation == OP_PAD_TRIGGER) ? in_ch.data.pad
			: {active_bank_q, in_ch.data.midi_note[3:0]};
		pad_ok = ({1'b0, pad_sel} < (PAD_W + 1)'(PADS));
		rel_ok = ({1'b0, in_ch.data.pad} < (PAD_W + 1)'(PADS));
		job_d  = JOB_NONE;
		fwd_d  = 1'b0;
		fpad_d = '0;
		key_note_d = {2'b00, in_ch.data.pad};
		case (in_ch.data.operation)
			OP_PAD_TRIGGER, OP_NOTE_ON: begin
				if (in_ch.data.operation == OP_NOTE_ON) begin
					key_note_d = in_ch.data.midi_note;
				end else begin
					key_note_d = {2'b00, pad_sel};
				end
				if (pad_ok) begin
					if (synth_mask_q[pad_sel]) begin
						fwd_d  = 1'b1;
						fpad_d = pad_sel;
					end else if (loaded_mask_q[pad_sel]) begin
						job_d = JOB_ALLOC;
					end
				end
			end
			OP_NOTE_OFF: begin
				key_note_d = in_ch.data.midi_note;
				job_d = JOB_NOTE_OFF;
			end
			OP_PAD_RELEASE: begin
				if (rel_ok) begin
					job_d = JOB_RELEASE;
					if (synth_mask_q[in_ch.data.pad]) begin
						fwd_d  = 1'b1;
						fpad_d = in_ch.data.pad;
					end
				end
			end
			OP_FINISHED: job_d = JOB_FINISH;
			OP_PANIC:    job_d = JOB_PANIC;
			default:     job_d = JOB_NONE;
		endcase
	end

	// capture of the item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fwd_q        <= fwd_d;
			fpad_q       <= fpad_d;
			key_note_q   <= key_note_d;
			vel_q        <= in_ch.data.velocity;
			track_q      <= in_ch.data.track;
			tag_q        <= in_ch.data.trigger_tag;
			is_trigger_q <= (in_ch.data.operation == OP_PAD_TRIGGER);
			store_tag_q  <= (in_ch.data.operation == OP_PAD_TRIGGER)
				? in_ch.data.trigger_tag : '0;
			slot_q       <= in_ch.data.voice_slot;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_q      <= JOB_NONE;
			scan_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				job_q <= job_d;
			end
			if (state_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + VW'(1);
			end else begin
				scan_idx_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (job_d == JOB_ALLOC || job_d == JOB_NOTE_OFF || job_d == JOB_RELEASE) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_UPDATE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == VW'(VOICES - 1)) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// voice table read, one entry per cycle
	always_ff @(posedge clk) begin
		age_s1    <= age_mem[scan_idx_q];
		note_s1   <= note_mem[scan_idx_q];
		track_s1  <= track_mem[scan_idx_q];
		trig_s1   <= trig_mem[scan_idx_q];
		active_s1 <= voice_active_q[scan_idx_q];
		idx_s1    <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
		end
	end

	// match terms for the entry in the read stage
	always_comb begin
		idx_ext_s1   = {{SLOT_W{1'b0}}, idx_s1};
		in_mask_s1   = (idx_ext_s1 < (VW + SLOT_W)'(MASK_W));
		note_off_hit = active_s1 && (note_s1 == key_note_q);
		release_hit  = active_s1 && (note_s1 == key_note_q)
			&& (track_q == {{(TRK_W - TW){1'b0}}, track_s1})
			&& (tag_q == '0 || trig_s1 == tag_q);
	end

	// shared compare unit: first free voice, oldest stamp, stop mask
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			free_found_q <= 1'b0;
			mask_q       <= '0;
		end else if (valid_s1) begin
			if (!active_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (idx_s1 == '0 || age_s1 < best_age_q) begin
				best_age_q <= age_s1;
				best_idx_q <= idx_s1;
			end
			if (in_mask_s1 && ((job_q == JOB_NOTE_OFF && note_off_hit)
				|| (job_q == JOB_RELEASE && release_hit))) begin
				mask_q[idx_ext_s1[SLOT_W-1:0]] <= 1'b1;
			end
		end
	end

	// update terms
	always_comb begin
		alloc_idx   = free_found_q ? free_idx_q : best_idx_q;
		alloc_ext   = {{SLOT_W{1'b0}}, alloc_idx};
		slot_ext    = {{VW{1'b0}}, slot_q};
		slot_idx    = slot_ext[VW-1:0];
		slot_ok     = (32'(slot_q) < 32'(VOICES));
		store_track = !is_trigger_q ? TW'(1)
			: (track_q > TRK_W'(TRACKS - 1)) ? TW'(TRACKS - 1) : track_q[TW-1:0];
		case (job_q)
			JOB_ALLOC:  cnt_next = free_found_q ? active_cnt_q + CW'(1) : active_cnt_q;
			JOB_FINISH: cnt_next = (slot_ok && voice_active_q[slot_idx])
				? active_cnt_q - CW'(1) : active_cnt_q;
			JOB_PANIC:  cnt_next = '0;
			default:    cnt_next = active_cnt_q;
		endcase
		cnt_ext = {{CNT_W{1'b0}}, cnt_next};
	end

	// result assembly
	always_comb begin
		res_d = '0;
		res_d.forwarded_to_synth = fwd_q;
		res_d.forwarded_pad      = fpad_q;
		res_d.active_count       = cnt_ext[CNT_W-1:0];
		if (job_q == JOB_NOTE_OFF || job_q == JOB_RELEASE) begin
			res_d.stop_mask = mask_q;
		end
		if (job_q == JOB_ALLOC) begin
			res_d.voice_started  = 1'b1;
			res_d.started_slot   = alloc_ext[SLOT_W-1:0];
			res_d.stole_voice    = !free_found_q;
			res_d.start_note     = key_note_q;
			res_d.start_velocity = vel_q;
		end
	end

	// voice table write at allocation
	always_ff @(posedge clk) begin
		if (do_update && job_q == JOB_ALLOC) begin
			age_mem[alloc_idx]   <= age_counter_q;
			note_mem[alloc_idx]  <= key_note_q;
			track_mem[alloc_idx] <= store_track;
			trig_mem[alloc_idx]  <= store_tag_q;
		end
	end

	// voice activity, count and age counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_active_q <= '0;
			active_cnt_q   <= '0;
			age_counter_q  <= '0;
		end else if (do_update) begin
			active_cnt_q <= cnt_next;
			case (job_q)
				JOB_ALLOC: begin
					voice_active_q[alloc_idx] <= 1'b1;
					age_counter_q <= age_counter_q + AGE_W'(1);
				end
				JOB_FINISH: begin
					if (slot_ok) begin
						voice_active_q[slot_idx] <= 1'b0;
					end
				end
				JOB_PANIC: voice_active_q <= '0;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_update) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			out_data_q <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	// running count tracks the activity bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		active_cnt_q == CW'($countones(voice_active_q)))
		else $error("active count out of step with voice activity");

	// no new item while one is in work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ch.ready)
		else $error("input taken while an item is in work");

	// a steal only comes with a started voice
	a_steal_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.stole_voice |-> out_data_q.voice_started)
		else $error("steal reported without a start");

	// an allocation that steals needs every voice busy
	a_steal_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_update && job_q == JOB_ALLOC && !free_found_q |-> &voice_active_q)
		else $error("voice stolen while a free voice exists");
`endif

endmodule
